// ----- rtl/bsa_pkg.sv -----
package bsa_pkg;

    // Map geometry
    localparam int MAX_SLOTS = 1024;
    localparam int WORD_BITS = 64;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int NUM_WORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W    = $clog2(NUM_WORDS);
    localparam int SLOT_W    = 10;
    localparam int CNT_W     = 11;

    // Request kinds
    typedef enum logic [1:0] {
        OP_ALLOC      = 2'd0,
        OP_ALLOC_PAIR = 2'd1,
        OP_FREE       = 2'd2,
        OP_QUERY      = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_SPACE    = 2'd1,
        ST_RANGE       = 2'd2,
        ST_DOUBLE_FREE = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_ACCESS,
        S_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // latch request beat
        logic scan;      // evaluate one map word
        logic access;    // free or query one slot
        logic out_load;  // move result into output register
    } bsa_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_hit;
        logic scan_last;
        logic out_free;
    } bsa_stat_t;

    // Index of the lowest set bit (don't care for zero)
    function automatic logic [BIT_W-1:0] ffs_word(input logic [WORD_BITS-1:0] v);
        logic [WORD_BITS-1:0] one;
        logic [BIT_W-1:0]     pos;
        one = v & (~v + {{(WORD_BITS-1){1'b0}}, 1'b1});
        pos = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (one[i])
            begin
                pos = pos | BIT_W'(i);
            end
        end
        return pos;
    endfunction

    // Free bits of map word w right after (re)initialization for sc slots
    function automatic logic [WORD_BITS-1:0] init_word(input logic [WIDX_W-1:0] w,
                                                       input logic [CNT_W-1:0]  sc);
        logic [CNT_W-BIT_W-1:0] full;
        logic [BIT_W-1:0]       rem;
        logic [WORD_BITS-1:0]   word;
        full = sc[CNT_W-1:BIT_W];
        rem  = sc[BIT_W-1:0];
        if ((CNT_W-BIT_W)'(w) < full)
        begin
            word = '1;
        end
        else if ((CNT_W-BIT_W)'(w) == full && rem != '0)
        begin
            word = ~({WORD_BITS{1'b1}} << rem);
        end
        else
        begin
            word = '0;
        end
        return word;
    endfunction

endpackage

// ----- rtl/bitmap_slot_allocator_core.sv -----
// Free and query load the request, access one slot, then wait for a free output
// register; allocations scan n map words (1 to 16) from the hint word instead.
// The scan checks one 64-bit map word per cycle; a new request is taken only
// once the last result has moved into the output register.
// Reset (rst_n low, asynchronous): 1024 slots, all free, hint word zero,
// output empty. A slot_count write reinitializes the map, hint and counter.
module bitmap_slot_allocator_core (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data,   // slot_count
    // Request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [9:0] slot_index, [15:10] zero
    input  logic [1:0]  s_axis_tuser,  // [1:0] op
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // [9:0] granted_index, [10] is_taken,
                                       // [21:11] free_total, [23:22] zero
    output logic [1:0]  m_axis_tuser   // [1:0] status
);
    import bsa_pkg::*;

    bsa_cmd_t           cmd;
    bsa_stat_t          stat;
    logic [SLOT_W-1:0]  out_granted;
    logic [1:0]         out_status;
    logic               out_taken;
    logic [CNT_W-1:0]   out_free_total;

    // Sequencer
    bsa_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_is_alloc (!s_axis_tuser[1]),
        .stat        (stat),
        .in_ready    (s_axis_tready),
        .cmd         (cmd)
    );

    // Map, counters and result registers
    bsa_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_op          (s_axis_tuser),
        .in_index       (s_axis_tdata[SLOT_W-1:0]),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .out_granted    (out_granted),
        .out_status     (out_status),
        .out_taken      (out_taken),
        .out_free_total (out_free_total)
    );

    // Result beat packing
    assign m_axis_tdata = {2'b00, out_free_total, out_taken, out_granted};
    assign m_axis_tuser = out_status;

endmodule

// ----- rtl/bsa_ctrl.sv -----
module bsa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_is_alloc,
    input  bsa_pkg::bsa_stat_t stat,
    output logic              in_ready,
    output bsa_pkg::bsa_cmd_t  cmd
);
    import bsa_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = in_is_alloc ? S_SCAN : S_ACCESS;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_hit || stat.scan_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_ACCESS:
            begin
                cmd.access = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/bsa_datapath.sv -----
module bsa_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bsa_pkg::bsa_cmd_t           cmd,
    output bsa_pkg::bsa_stat_t          stat,
    input  logic [1:0]                  in_op,
    input  logic [bsa_pkg::SLOT_W-1:0]  in_index,
    input  logic                        cfg_wr_en,
    input  logic [bsa_pkg::CNT_W-1:0]   cfg_wr_data,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [bsa_pkg::SLOT_W-1:0]  out_granted,
    output logic [1:0]                  out_status,
    output logic                        out_taken,
    output logic [bsa_pkg::CNT_W-1:0]   out_free_total
);
    import bsa_pkg::*;

    // Persistent allocator state
    logic [WORD_BITS-1:0] map_reg [NUM_WORDS];
    logic [WIDX_W-1:0]    hint_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     slot_count_reg;
    logic                 out_valid_reg;

    // Request and result holding
    op_t                  op_reg;
    logic [SLOT_W-1:0]    idx_reg;
    logic [WIDX_W-1:0]    w_reg;
    logic                 cand_reg;
    logic [SLOT_W-1:0]    res_granted_reg;
    status_t              res_status_reg;
    logic                 res_taken_reg;
    logic [SLOT_W-1:0]    out_granted_reg;
    status_t              out_status_reg;
    logic                 out_taken_reg;
    logic [CNT_W-1:0]     out_free_reg;

    logic [CNT_W-1:0]     sc_m1;
    logic [WIDX_W-1:0]    last_word;
    logic [CNT_W-1:0]     cfg_clamp;
    logic [WORD_BITS-1:0] cur_word;
    logic [WORD_BITS-1:0] pair_vec;
    logic [BIT_W-1:0]     single_bit;
    logic [BIT_W-1:0]     pair_bit;
    logic [WIDX_W-1:0]    prev_w;
    logic                 is_single;
    logic                 straddle;
    logic                 in_range;
    logic                 scan_hit;
    logic [WIDX_W-1:0]    acc_wi;
    logic [BIT_W-1:0]     acc_pos;
    logic [WORD_BITS-1:0] acc_word;
    logic                 acc_bit;
    logic                 acc_oor;

    // Clamp of the written slot count
    always_comb
    begin
        cfg_clamp = cfg_wr_data;
        if (cfg_wr_data == '0)
        begin
            cfg_clamp = CNT_W'(1);
        end
        else if (cfg_wr_data > CNT_W'(MAX_SLOTS))
        begin
            cfg_clamp = CNT_W'(MAX_SLOTS);
        end
    end

    // Last used word of the map
    assign sc_m1     = slot_count_reg - CNT_W'(1);
    assign last_word = sc_m1[BIT_W +: WIDX_W];

    // Scan of one word
    assign cur_word   = map_reg[w_reg];
    assign pair_vec   = cur_word & (cur_word >> 1);
    assign single_bit = ffs_word(cur_word);
    assign pair_bit   = ffs_word(pair_vec);
    assign prev_w     = w_reg - WIDX_W'(1);
    assign is_single  = (op_reg == OP_ALLOC);
    assign straddle   = cand_reg & cur_word[0];
    assign in_range   = (w_reg <= last_word);
    assign scan_hit   = in_range &&
                        (is_single ? (|cur_word) : (straddle || (|pair_vec)));

    // Single-slot access
    assign acc_wi   = idx_reg[BIT_W +: WIDX_W];
    assign acc_pos  = idx_reg[BIT_W-1:0];
    assign acc_word = map_reg[acc_wi];
    assign acc_bit  = acc_word[acc_pos];
    assign acc_oor  = ({1'b0, idx_reg} >= slot_count_reg);

    assign stat.scan_hit  = scan_hit;
    assign stat.scan_last = (w_reg >= last_word);
    assign stat.out_free  = !out_valid_reg || out_ready;

    // Map, hint, counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < NUM_WORDS; w++)
            begin
                map_reg[w] <= '1;
            end
            hint_reg       <= '0;
            cnt_reg        <= CNT_W'(MAX_SLOTS);
            slot_count_reg <= CNT_W'(MAX_SLOTS);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // Output register handshake
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_wr_en)
            begin
                // Reinitialize as at reset
                for (int w = 0; w < NUM_WORDS; w++)
                begin
                    map_reg[w] <= init_word(WIDX_W'(w), cfg_clamp);
                end
                slot_count_reg <= cfg_clamp;
                hint_reg       <= '0;
                cnt_reg        <= cfg_clamp;
            end
            else if (cmd.scan && scan_hit)
            begin
                if (is_single)
                begin
                    map_reg[w_reg][single_bit] <= 1'b0;
                    hint_reg <= w_reg;
                    cnt_reg  <= cnt_reg - CNT_W'(1);
                end
                else
                begin
                    if (straddle)
                    begin
                        map_reg[w_reg][0]              <= 1'b0;
                        map_reg[prev_w][WORD_BITS-1]   <= 1'b0;
                    end
                    else
                    begin
                        map_reg[w_reg] <= cur_word & ~({{(WORD_BITS-2){1'b0}}, 2'b11}
                                                       << pair_bit);
                    end
                    cnt_reg <= cnt_reg - CNT_W'(2);
                end
            end
            else if (cmd.access && op_reg == OP_FREE && !acc_oor && !acc_bit)
            begin
                map_reg[acc_wi][acc_pos] <= 1'b1;
                if (hint_reg > acc_wi)
                begin
                    hint_reg <= acc_wi;
                end
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    // Request, scan position and results
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op_t'(in_op);
            idx_reg  <= in_index;
            w_reg    <= hint_reg;
            cand_reg <= 1'b0;
        end

        if (cmd.scan)
        begin
            res_taken_reg <= 1'b0;
            if (scan_hit)
            begin
                res_status_reg <= ST_OK;
                if (is_single)
                begin
                    res_granted_reg <= {w_reg, single_bit};
                end
                else if (straddle)
                begin
                    res_granted_reg <= {prev_w, BIT_W'(WORD_BITS - 1)};
                end
                else
                begin
                    res_granted_reg <= {w_reg, pair_bit};
                end
            end
            else
            begin
                res_status_reg  <= ST_NO_SPACE;
                res_granted_reg <= '0;
                w_reg           <= w_reg + WIDX_W'(1);
                // Top bit free with no pair inside: may pair with next word
                cand_reg        <= (|cur_word) && !(|pair_vec) && cur_word[WORD_BITS-1];
            end
        end

        if (cmd.access)
        begin
            res_granted_reg <= '0;
            res_taken_reg   <= 1'b0;
            if (acc_oor)
            begin
                res_status_reg <= ST_RANGE;
            end
            else if (op_reg == OP_FREE)
            begin
                res_status_reg <= acc_bit ? ST_DOUBLE_FREE : ST_OK;
            end
            else
            begin
                res_status_reg <= ST_OK;
                res_taken_reg  <= !acc_bit;
            end
        end

        if (cmd.out_load)
        begin
            out_granted_reg <= res_granted_reg;
            out_status_reg  <= res_status_reg;
            out_taken_reg   <= res_taken_reg;
            out_free_reg    <= cnt_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_granted    = out_granted_reg;
    assign out_status     = out_status_reg;
    assign out_taken      = out_taken_reg;
    assign out_free_total = out_free_reg;

endmodule

// ----- test/tb_bitmap_slot_allocator_core.sv -----
`timescale 1ns / 100ps

module tb_bitmap_slot_allocator_core;

    import bsa_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int END_WAIT    = 20;
    localparam int MAX_REPORTS = 10;

    // One result beat as the block reports it
    typedef struct {
        logic [SLOT_W-1:0] granted;
        status_t           status;
        logic              taken;
        logic [CNT_W-1:0]  free_total;
    } slot_result_t;

    // Tracks the slot map, predicts each result and checks the result beats
    class slot_map_scoreboard;
        logic [WORD_BITS-1:0] free_map [NUM_WORDS];
        int unsigned          hint_word;
        int unsigned          free_cnt;
        int unsigned          slots;
        slot_result_t         awaited_results [$];
        int unsigned          errors;

        function new();
            errors = 0;
            configure(11'(MAX_SLOTS));
        endfunction

        // New slot count: clamp, then reinitialize the whole map
        function void configure(logic [CNT_W-1:0] value);
            int unsigned v;
            v = value;
            if (v == 0)
            begin
                v = 1;
            end
            if (v > MAX_SLOTS)
            begin
                v = MAX_SLOTS;
            end
            slots = v;
            for (int w = 0; w < NUM_WORDS; w++)
            begin
                for (int b = 0; b < WORD_BITS; b++)
                begin
                    free_map[w][b] = ((w * WORD_BITS + b) < v);
                end
            end
            hint_word = 0;
            free_cnt  = v;
        endfunction

        function bit is_taken(int unsigned idx);
            return !free_map[idx / WORD_BITS][idx % WORD_BITS];
        endfunction

        function int unsigned pending();
            return awaited_results.size();
        endfunction

        // Accepted request beat: update the map and queue the expected result
        function void note_request(op_t op, logic [SLOT_W-1:0] idx);
            slot_result_t res;
            int unsigned  nw;
            int unsigned  w;
            int unsigned  b;
            bit           found;
            res.granted = '0;
            res.status  = ST_OK;
            res.taken   = 1'b0;
            nw    = (slots + WORD_BITS - 1) / WORD_BITS;
            found = 1'b0;
            case (op)
                OP_ALLOC:
                begin
                    // lowest free slot from the hint word up; hint follows the grant
                    for (w = hint_word; w < nw && !found; w++)
                    begin
                        if (free_map[w] != '0)
                        begin
                            b = 0;
                            while (!free_map[w][b])
                            begin
                                b++;
                            end
                            free_map[w][b] = 1'b0;
                            hint_word      = w;
                            free_cnt--;
                            res.granted    = SLOT_W'(w * WORD_BITS + b);
                            found          = 1'b1;
                        end
                    end
                    if (!found)
                    begin
                        res.status = ST_NO_SPACE;
                    end
                end
                OP_ALLOC_PAIR:
                begin
                    // lowest adjacent pair inside a word, else across the word edge
                    for (w = hint_word; w < nw && !found; w++)
                    begin
                        for (b = 0; b + 1 < WORD_BITS && !found; b++)
                        begin
                            if (free_map[w][b] && free_map[w][b+1])
                            begin
                                free_map[w][b]   = 1'b0;
                                free_map[w][b+1] = 1'b0;
                                res.granted      = SLOT_W'(w * WORD_BITS + b);
                                found            = 1'b1;
                            end
                        end
                        if (!found && w + 1 < nw && free_map[w][WORD_BITS-1] &&
                            free_map[w+1][0])
                        begin
                            free_map[w][WORD_BITS-1] = 1'b0;
                            free_map[w+1][0]         = 1'b0;
                            res.granted = SLOT_W'(w * WORD_BITS + WORD_BITS - 1);
                            found       = 1'b1;
                        end
                    end
                    if (found)
                    begin
                        free_cnt -= 2;
                    end
                    else
                    begin
                        res.status = ST_NO_SPACE;
                    end
                end
                default:
                begin
                    // free or query one slot
                    if (idx >= slots)
                    begin
                        res.status = ST_RANGE;
                    end
                    else
                    begin
                        w = idx / WORD_BITS;
                        b = idx % WORD_BITS;
                        if (op == OP_FREE)
                        begin
                            if (free_map[w][b])
                            begin
                                res.status = ST_DOUBLE_FREE;
                            end
                            else
                            begin
                                free_map[w][b] = 1'b1;
                                if (hint_word > w)
                                begin
                                    hint_word = w;
                                end
                                free_cnt++;
                            end
                        end
                        else
                        begin
                            res.taken = !free_map[w][b];
                        end
                    end
                end
            endcase
            res.free_total = CNT_W'(free_cnt);
            awaited_results.push_back(res);
        endfunction

        // Accepted result beat: compare with the oldest expectation
        function void check_result(logic [SLOT_W-1:0] granted, logic taken,
                                   logic [CNT_W-1:0] free_total, logic [1:0] status);
            slot_result_t exp_res;
            if (awaited_results.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $display("%0t: result beat with nothing expected: granted=%0d status=%0d",
                             $realtime, granted, status);
                end
                return;
            end
            exp_res = awaited_results.pop_front();
            if (granted !== exp_res.granted || status !== exp_res.status ||
                taken !== exp_res.taken || free_total !== exp_res.free_total)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $display({"%0t: mismatch exp granted=%0d status=%0d taken=%0d free=%0d",
                              " / got granted=%0d status=%0d taken=%0d free=%0d"},
                             $realtime, exp_res.granted, exp_res.status, exp_res.taken,
                             exp_res.free_total, granted, status, taken, free_total);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [10:0] cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [9:0] slot_index, [15:10] zero
    logic [1:0]  s_axis_tuser;   // [1:0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [9:0] granted_index, [10] is_taken,
                                 // [21:11] free_total, [23:22] zero
    logic [1:0]  m_axis_tuser;   // [1:0] status

    slot_map_scoreboard sb;
    bit                 no_idle = 1'b0;
    int unsigned        quiet_cycles = 0;

    bitmap_slot_allocator_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
        begin
            return 0;
        end
        else if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Result side back-pressure
    initial
    begin
        int unsigned span;
        forever
        begin
            span = idle_span();
            if (span != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (span) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_result(m_axis_tdata[9:0], m_axis_tdata[10], m_axis_tdata[21:11],
                            m_axis_tuser);
        end
    end

    // Watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_bitmap_slot_allocator_core: FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One request beat; valid stays high when the next beat follows at once
    task automatic send_request(op_t op, logic [SLOT_W-1:0] idx);
        int unsigned gap;
        gap = idle_span();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, idx};
        s_axis_tuser  <= op;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        sb.note_request(op, idx);
    endtask

    // Hold the request side until every expected result is back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_slot_count(logic [CNT_W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.configure(value);
        repeat (2) @(posedge clk);
    endtask

    // Random requests; alloc_pct sets the share of allocations
    task automatic run_phase(int unsigned count, int unsigned alloc_pct);
        op_t               op;
        logic [SLOT_W-1:0] idx;
        int unsigned       r;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 49) == 0)
            begin
                drain_results();
            end
            r = $urandom_range(0, 99);
            if (r < alloc_pct / 2)
            begin
                op = OP_ALLOC;
            end
            else if (r < alloc_pct)
            begin
                op = OP_ALLOC_PAIR;
            end
            else if ($urandom_range(0, 2) != 0)
            begin
                op = OP_FREE;
            end
            else
            begin
                op = OP_QUERY;
            end
            // mostly in-range slots, preferring taken ones; some anywhere
            idx = SLOT_W'($urandom_range(0, 1023));
            r   = $urandom_range(0, 99);
            if (r < 80)
            begin
                idx = SLOT_W'($urandom_range(0, sb.slots - 1));
                for (int t = 0; t < 8 && r < 50 && !sb.is_taken(idx); t++)
                begin
                    idx = SLOT_W'($urandom_range(0, sb.slots - 1));
                end
            end
            send_request(op, idx);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_ALLOC;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // After reset: all 1024 slots free
        send_request(OP_QUERY, 10'd5);
        send_request(OP_QUERY, 10'd1023);
        send_request(OP_ALLOC, 10'd0);
        send_request(OP_ALLOC_PAIR, 10'd1023);
        send_request(OP_QUERY, 10'd0);
        send_request(OP_QUERY, 10'd2);
        send_request(OP_FREE, 10'd0);
        send_request(OP_FREE, 10'd0);
        send_request(OP_FREE, 10'd1023);
        send_request(OP_ALLOC, 10'd0);
        send_request(OP_FREE, 10'd2);
        send_request(OP_ALLOC_PAIR, 10'd0);

        // Clamp above the maximum, then a single slot
        write_slot_count(11'd2047);
        write_slot_count(11'd0);
        send_request(OP_ALLOC_PAIR, 10'd0);
        send_request(OP_ALLOC, 10'd0);
        send_request(OP_ALLOC, 10'd0);
        send_request(OP_QUERY, 10'd0);
        send_request(OP_QUERY, 10'd1);
        send_request(OP_FREE, 10'd1023);
        send_request(OP_FREE, 10'd0);

        // Fill word 0 so that the next pair straddles into word 1
        write_slot_count(11'd128);
        repeat (31) send_request(OP_ALLOC_PAIR, 10'd0);
        send_request(OP_ALLOC, 10'd0);
        send_request(OP_ALLOC_PAIR, 10'd0);
        send_request(OP_QUERY, 10'd64);
        send_request(OP_ALLOC, 10'd0);

        // Random phases over several map sizes
        write_slot_count(11'd1);
        run_phase(40, 50);
        write_slot_count(11'd2);
        run_phase(40, 50);
        write_slot_count(11'd3);
        run_phase(40, 50);
        write_slot_count(11'd63);
        run_phase(40, 65);
        write_slot_count(11'd64);
        run_phase(40, 65);
        write_slot_count(11'd65);
        run_phase(40, 65);
        write_slot_count(11'd127);
        run_phase(40, 70);
        write_slot_count(11'd129);
        run_phase(40, 70);
        write_slot_count(CNT_W'($urandom_range(1, 2047)));
        run_phase(40, 55);
        write_slot_count(11'd1024);
        no_idle = 1'b1;
        run_phase(40, 55);
        no_idle = 1'b0;

        drain_results();
        repeat (END_WAIT) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("tb_bitmap_slot_allocator_core: PASS");
        end
        else
        begin
            $display("tb_bitmap_slot_allocator_core: FAIL");
        end
        $finish;
    end

endmodule
